// ===== design/ape_pkg.sv =====
package ape_pkg;

    localparam int unsigned ByteW = 8;

    localparam logic [4:0] AvcTypeSps  = 5'd7;
    localparam logic [4:0] AvcTypePps  = 5'd8;
    localparam logic [5:0] HevcTypeVps = 6'd32;
    localparam logic [5:0] HevcTypeSps = 6'd33;
    localparam logic [5:0] HevcTypePps = 6'd34;

    localparam logic [ByteW-1:0] ByteZero = 8'h00;
    localparam logic [ByteW-1:0] ByteOne  = 8'h01;

    // output burst caused by one input byte:
    // zeros, then 0x01 if one, then dbyte if data, then marker if mark
    typedef struct packed {
        logic [2:0]       zeros;
        logic             one;
        logic             data;
        logic             mark;
        logic [ByteW-1:0] dbyte;
    } t_desc;

    function automatic logic param_header(input logic [ByteW-1:0] hdr, input logic hevc);
        logic [5:0] htype;
        logic [4:0] atype;
        htype = hdr[6:1];
        atype = hdr[4:0];
        if (hevc) begin
            return (htype == HevcTypeVps) || (htype == HevcTypeSps) || (htype == HevcTypePps);
        end
        return (atype == AvcTypeSps) || (atype == AvcTypePps);
    endfunction

endpackage

// ===== design/ape_core.sv =====
module ape_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic                 i_hevc,
    output logic                 o_push,
    output ape_pkg::t_desc       o_desc
);
    import ape_pkg::*;

    typedef enum logic [3:0] {
        PH_SEEK   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_PASS   = 4'b0100,
        PH_SKIP   = 4'b1000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [1:0] r_zero_run, n_zero_run;
    logic       r_emitted, n_emitted;
    logic       r_done, n_done;
    t_desc      desc;

    always_comb begin
        n_phase    = r_phase;
        n_zero_run = r_zero_run;
        n_emitted  = r_emitted;
        n_done     = r_done;
        desc       = '0;
        desc.dbyte = i_byte;

        if (!r_done) begin
            if (r_phase == PH_HEADER) begin
                if (param_header(i_byte, i_hevc)) begin
                    desc.zeros = 3'd3;
                    desc.one   = 1'b1;
                    desc.data  = 1'b1;
                    n_phase    = PH_PASS;
                    n_zero_run = 2'd0;
                end else begin
                    n_phase    = PH_SKIP;
                    n_zero_run = {1'b0, (i_byte == ByteZero)};
                end
            end else if (i_byte == ByteZero) begin
                if (r_zero_run != 2'd3) begin
                    n_zero_run = r_zero_run + 2'd1;
                end else if (r_phase == PH_PASS) begin
                    desc.zeros = 3'd1;
                end
            end else if ((i_byte == ByteOne) && r_zero_run[1]) begin
                n_phase    = PH_HEADER;
                n_zero_run = 2'd0;
            end else begin
                if (r_phase == PH_PASS) begin
                    desc.zeros = {1'b0, r_zero_run};
                    desc.data  = 1'b1;
                end
                n_zero_run = 2'd0;
            end

            if ((desc.zeros != 3'd0) || desc.data) begin
                n_emitted = 1'b1;
            end

            if (i_last) begin
                if (n_phase == PH_PASS) begin
                    desc.zeros = desc.zeros + {1'b0, n_zero_run};
                    if (n_zero_run != 2'd0) begin
                        n_emitted = 1'b1;
                    end
                end
                if (n_emitted) begin
                    desc.mark = 1'b1;
                    n_done    = 1'b1;
                end
                n_phase    = PH_SEEK;
                n_zero_run = 2'd0;
                n_emitted  = 1'b0;
            end
        end
    end

    assign o_push = i_accept && !r_done && ((desc.zeros != 3'd0) || desc.data || desc.mark);
    assign o_desc = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SEEK;
            r_zero_run <= 2'd0;
            r_emitted  <= 1'b0;
            r_done     <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_zero_run <= n_zero_run;
            r_emitted  <= n_emitted;
            r_done     <= n_done;
        end
    end

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("done flag cleared");

    a_no_push_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !o_push)
        else $error("request produced after done");

endmodule

// ===== design/ape_fifo.sv =====
module ape_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ape_pkg::t_desc i_desc,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output ape_pkg::t_desc o_desc
);
    import ape_pkg::*;

    t_desc      r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_desc  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

endmodule

// ===== design/ape_ser.sv =====
module ape_ser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ape_pkg::t_desc i_desc,
    output logic           o_pop,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [7:0]     o_m_tdata,
    output logic           o_m_tuser,
    output logic           o_m_tlast
);
    import ape_pkg::*;

    logic             r_busy;
    logic [2:0]       r_zleft;
    logic             r_one, r_data, r_mark;
    logic [ByteW-1:0] r_byte;
    logic [2:0]       remaining;
    logic             is_last, take, load;

    assign remaining = r_zleft + {2'b0, r_one} + {2'b0, r_data} + {2'b0, r_mark};
    assign is_last   = (remaining == 3'd1);
    assign take      = r_busy && i_m_tready;
    assign load      = (!r_busy || (take && is_last)) && i_valid;
    assign o_pop     = load;

    assign o_m_tvalid = r_busy;
    assign o_m_tlast  = is_last;
    assign o_m_tuser  = (r_zleft == 3'd0) && !r_one && !r_data;
    assign o_m_tdata  = (r_zleft != 3'd0) ? ByteZero :
                        r_one             ? ByteOne  :
                        r_data            ? r_byte   : ByteZero;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_desc.dbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_zleft <= 3'd0;
            r_one   <= 1'b0;
            r_data  <= 1'b0;
            r_mark  <= 1'b0;
        end else if (load) begin
            r_busy  <= 1'b1;
            r_zleft <= i_desc.zeros;
            r_one   <= i_desc.one;
            r_data  <= i_desc.data;
            r_mark  <= i_desc.mark;
        end else if (take && is_last) begin
            r_busy  <= 1'b0;
            r_zleft <= 3'd0;
            r_one   <= 1'b0;
            r_data  <= 1'b0;
            r_mark  <= 1'b0;
        end else if (take) begin
            if (r_zleft != 3'd0) begin
                r_zleft <= r_zleft - 3'd1;
            end else if (r_one) begin
                r_one <= 1'b0;
            end else if (r_data) begin
                r_data <= 1'b0;
            end else begin
                r_mark <= 1'b0;
            end
        end
    end

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("marker not last of burst");

    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (remaining != 3'd0))
        else $error("busy with empty burst");

endmodule

// ===== design/annexb_parameter_set_extractor_top.sv =====
// Channel   Dir  Handshake                  Payload
// s         in   i_s_tvalid / o_s_tready    i_s_tdata = in_byte, i_s_tlast = unit_end
// m         out  o_m_tvalid / i_m_tready    o_m_tdata = out_byte, o_m_tuser = kind,
//                                           o_m_tlast = run_last
// cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_data = hevc_mode
//
// One input byte accepted per cycle while the 2-deep burst queue has room.
// Each byte yields 0 to 6 output requests, sent one per cycle by the serializer while i_m_tready is high;
// sustained input rate is one byte per cycle while each byte yields at most one request.
// Synchronous active-low reset clears parser state, queue and serializer.
// Output stalls back up through the queue to o_s_tready; cfg is always ready.
module annexb_parameter_set_extractor_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tuser,   // [0] kind
    output logic       o_m_tlast,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    import ape_pkg::*;

    logic  r_hevc;
    logic  accept, push, full, q_valid, pop;
    t_desc core_desc, q_desc;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !full;
    assign accept      = i_s_tvalid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hevc <= 1'b0;
        end else if (i_cfg_valid) begin
            r_hevc <= i_cfg_data;
        end
    end

    ape_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_hevc   (r_hevc),
        .o_push   (push),
        .o_desc   (core_desc)
    );

    ape_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (core_desc),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    ape_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_desc     (q_desc),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
